// ----- hdl/tmq_pkg.sv -----
// ----------------------------------------------------------------------------
// tmq_pkg: shared types and codes of the tagged message match queue
// Request codes, the store record and the fetch filter handed to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

	// request kinds carried on the input tuser
	localparam logic ACT_STORE = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	// fixed field widths of the stream payload
	localparam int SLOT_W  = 5;
	localparam int SRC_W   = 6;
	localparam int TAG_W   = 16;
	localparam int SEQIN_W = 32;
	localparam int SIZE_W  = 16;
	localparam int ROOM_W  = 20;

	// packet written into one slot by a store request
	typedef struct packed {
		logic               is_tail;
		logic [SRC_W-1:0]   source_host;
		logic [TAG_W-1:0]   packet_tag;
		logic [SEQIN_W-1:0] seq_number;
		logic [SIZE_W-1:0]  packet_size;
	} tmq_store_t;

	// source and tag filter of a fetch request
	typedef struct packed {
		logic             any_source;
		logic [SRC_W-1:0] want_source;
		logic             any_tag;
		logic [TAG_W-1:0] want_tag;
	} tmq_filter_t;

endpackage

`default_nettype wire

// ----- hdl/tmq_cell.sv -----
// ----------------------------------------------------------------------------
// tmq_cell: one slot of the match queue
// Holds one packet and merges it into the best candidate passed along the row.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_cell import tmq_pkg::*; #(
	parameter int SLOT_INDEX = 0,
	parameter int IDX_W      = 5,
	parameter int HOST_BITS  = 6,
	parameter int SEQ_BITS   = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic                 clr_en,
	input  wire tmq_store_t           store,
	input  wire tmq_filter_t          filter,
	input  wire logic                 in_valid,
	input  wire logic [SEQ_BITS-1:0]  in_seq,
	input  wire logic [IDX_W-1:0]     in_idx,
	input  wire logic [HOST_BITS-1:0] in_src,
	input  wire logic [TAG_W-1:0]     in_tag,
	input  wire logic [SIZE_W-1:0]    in_size,
	input  wire logic                 in_tail,
	output logic                      out_valid,
	output logic [SEQ_BITS-1:0]       out_seq,
	output logic [IDX_W-1:0]          out_idx,
	output logic [HOST_BITS-1:0]      out_src,
	output logic [TAG_W-1:0]          out_tag,
	output logic [SIZE_W-1:0]         out_size,
	output logic                      out_tail
);

	localparam logic [IDX_W-1:0] OWN_IDX = IDX_W'(SLOT_INDEX);

	logic                 occupied_q;
	logic                 tail_q;
	logic [HOST_BITS-1:0] src_q;
	logic [TAG_W-1:0]     tag_q;
	logic [SEQ_BITS-1:0]  seq_q;
	logic [SIZE_W-1:0]    size_q;
	logic                 match;
	logic [SEQ_BITS-1:0]  bound;
	logic                 take;

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= 1'b0;
		end else if (wr_en) begin
			occupied_q <= 1'b1;
		end else if (clr_en) begin
			occupied_q <= 1'b0;
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tail_q <= store.is_tail;
			src_q  <= HOST_BITS'(store.source_host);
			tag_q  <= store.packet_tag;
			seq_q  <= SEQ_BITS'(store.seq_number);
			size_q <= store.packet_size;
		end
	end

	// filter test and strict compare against the best so far
	always_comb begin
		match = occupied_q
			&& (filter.any_source || (16'(src_q) == 16'(filter.want_source)))
			&& (filter.any_tag || (tag_q == filter.want_tag));
		bound = in_valid ? in_seq : '1;
		take  = match && (seq_q < bound);
	end

	// candidate handed to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= take || in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_seq  <= seq_q;
			out_idx  <= OWN_IDX;
			out_src  <= src_q;
			out_tag  <= tag_q;
			out_size <= size_q;
			out_tail <= tail_q;
		end else begin
			out_seq  <= in_seq;
			out_idx  <= in_idx;
			out_src  <= in_src;
			out_tag  <= in_tag;
			out_size <= in_size;
			out_tail <= in_tail;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tagged_message_match_queue_core.sv -----
// A store request is written into its slot and the block stays ready.
// A fetch request gives its result once the best candidate has walked the
// row of slot cells one cell per cycle and has been registered at the output.
// No new request is taken while a fetch scans or waits to hand on its result.
// Reset (arst_n low) empties every slot and clears the running byte count;
// there is no clearing pass, the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// tagged_message_match_queue_core: tag matching receive queue
// Stores packets in slots and serves the lowest sequence number that passes
// the source and tag filters, tracking the bytes of the message assembled.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_message_match_queue_core import tmq_pkg::*; #(
	parameter int SLOT_COUNT = 32,
	parameter int HOST_BITS  = 6,
	parameter int SEQ_BITS   = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// slot[4:0] source_host[10:5] packet_tag_in[26:11] seq_number[58:27]
	// packet_size[74:59] want_any_source[75] want_source[81:76]
	// want_any_tag[82] want_tag[98:83] room_bytes[118:99], pad [119]
	input  wire logic [119:0] s_tdata,
	input  wire logic         s_tlast,    // is_tail
	input  wire logic         s_tuser,    // action
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// slot_taken[4:0] packet_source[10:5] packet_tag_out[26:11]
	// packet_was_tail[27] copy_offset[47:28] copy_bytes[63:48]
	output logic [63:0]       m_tdata,
	output logic              m_tlast,    // message_done
	output logic              m_tuser     // found
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   cnt_q;
	tmq_filter_t        filter_q;
	logic [ROOM_W-1:0]  room_q;
	logic [ROOM_W-1:0]  assembled_q;

	logic               in_req;
	logic               store_req;
	logic               fetch_req;
	logic               finish;
	tmq_store_t         store;

	logic [SLOT_COUNT-1:0] wr_en;
	logic [SLOT_COUNT-1:0] clr_en;

	logic                 ch_valid [SLOT_COUNT+1];
	logic [SEQ_BITS-1:0]  ch_seq   [SLOT_COUNT+1];
	logic [IDX_W-1:0]     ch_idx   [SLOT_COUNT+1];
	logic [HOST_BITS-1:0] ch_src   [SLOT_COUNT+1];
	logic [TAG_W-1:0]     ch_tag   [SLOT_COUNT+1];
	logic [SIZE_W-1:0]    ch_size  [SLOT_COUNT+1];
	logic                 ch_tail  [SLOT_COUNT+1];

	logic                 w_valid;
	logic [IDX_W-1:0]     w_idx;
	logic                 w_tail;
	logic [SIZE_W-1:0]    w_size;
	logic [ROOM_W-1:0]    avail;
	logic [SIZE_W-1:0]    copy_n;
	logic                 done_flag;

	// request decode
	assign s_tready  = (state_q == ST_IDLE);
	assign in_req    = s_tvalid && s_tready;
	assign store_req = in_req && (s_tuser == ACT_STORE);
	assign fetch_req = in_req && (s_tuser == ACT_FETCH);
	assign finish    = (state_q == ST_DONE) && (!m_tvalid || m_tready);

	assign store.is_tail     = s_tlast;
	assign store.source_host = s_tdata[10:5];
	assign store.packet_tag  = s_tdata[26:11];
	assign store.seq_number  = s_tdata[58:27];
	assign store.packet_size = s_tdata[74:59];

	// fetch filter and room held for the whole scan
	always_ff @(posedge clk) begin
		if (fetch_req) begin
			filter_q.any_source  <= s_tdata[75];
			filter_q.want_source <= s_tdata[81:76];
			filter_q.any_tag     <= s_tdata[82];
			filter_q.want_tag    <= s_tdata[98:83];
			room_q               <= s_tdata[118:99];
		end
	end

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (fetch_req) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_CNT) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// head of the row: no candidate yet
	assign ch_valid[0] = 1'b0;
	assign ch_seq[0]   = '1;
	assign ch_idx[0]   = '0;
	assign ch_src[0]   = '0;
	assign ch_tag[0]   = '0;
	assign ch_size[0]  = '0;
	assign ch_tail[0]  = 1'b0;

	// row of slot cells
	for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
		assign wr_en[k]  = store_req && (32'(s_tdata[4:0]) == k);
		assign clr_en[k] = finish && w_valid && (w_idx == IDX_W'(k));

		tmq_cell #(
			.SLOT_INDEX (k),
			.IDX_W      (IDX_W),
			.HOST_BITS  (HOST_BITS),
			.SEQ_BITS   (SEQ_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (wr_en[k]),
			.clr_en    (clr_en[k]),
			.store     (store),
			.filter    (filter_q),
			.in_valid  (ch_valid[k]),
			.in_seq    (ch_seq[k]),
			.in_idx    (ch_idx[k]),
			.in_src    (ch_src[k]),
			.in_tag    (ch_tag[k]),
			.in_size   (ch_size[k]),
			.in_tail   (ch_tail[k]),
			.out_valid (ch_valid[k+1]),
			.out_seq   (ch_seq[k+1]),
			.out_idx   (ch_idx[k+1]),
			.out_src   (ch_src[k+1]),
			.out_tag   (ch_tag[k+1]),
			.out_size  (ch_size[k+1]),
			.out_tail  (ch_tail[k+1])
		);
	end

	// winner at the end of the row and clamped copy length
	assign w_valid = ch_valid[SLOT_COUNT];
	assign w_idx   = ch_idx[SLOT_COUNT];
	assign w_tail  = ch_tail[SLOT_COUNT];
	assign w_size  = ch_size[SLOT_COUNT];

	always_comb begin
		avail     = (room_q > assembled_q) ? (room_q - assembled_q) : '0;
		copy_n    = (ROOM_W'(w_size) < avail) ? w_size : SIZE_W'(avail);
		done_flag = !w_valid || w_tail;
	end

	// running byte count of the message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assembled_q <= '0;
		end else if (finish) begin
			if (done_flag) begin
				assembled_q <= '0;
			end else begin
				assembled_q <= assembled_q + ROOM_W'(copy_n);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (finish) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tuser <= w_valid;
			m_tlast <= done_flag;
			if (w_valid) begin
				m_tdata <= {copy_n, assembled_q, w_tail, ch_tag[SLOT_COUNT],
					SRC_W'(ch_src[SLOT_COUNT]), SLOT_W'(w_idx)};
			end else begin
				m_tdata <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	// scan counter only runs during the scan
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SCAN) |-> (cnt_q == '0))
		else $error("scan counter active outside scan");

	// an accepted fetch starts a scan
	a_fetch_scan: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_req |=> (state_q == ST_SCAN))
		else $error("fetch did not start a scan");

	// finishing a fetch presents a result
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> m_tvalid)
		else $error("finished fetch gave no result");

	// at most one slot is freed, and never while storing
	a_clr_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(clr_en) && !((|clr_en) && (|wr_en)))
		else $error("slot clear conflict");
`endif

endmodule

`default_nettype wire
